@@ rtl/core/rpd_pkg.sv @@
// Package for the remote serial protocol packet deframer: constants, types, hex decode.
`default_nettype none
package rpd_pkg;

	localparam int unsigned MAX_PAYLOAD = 4096;
	localparam int unsigned LEN_W = 13;

	localparam logic [7:0] START_MARK = 8'h24;
	localparam logic [7:0] HASH_MARK = 8'h23;

	typedef enum logic [3:0] {
		PH_HUNT = 4'b0001,
		PH_PAYLOAD = 4'b0010,
		PH_DIGIT_HI = 4'b0100,
		PH_DIGIT_LO = 4'b1000
	} phase_t;

	typedef struct packed {
		logic ok;
		logic [3:0] val;
	} hex_t;

	function automatic hex_t hex_decode(input logic [7:0] c);
		hex_t h;
		h.ok = 1'b1;
		h.val = 4'd0;
		if (c inside {[8'h30:8'h39]}) begin
			h.val = 4'(c - 8'h30);
		end else if (c inside {[8'h61:8'h66]}) begin
			h.val = 4'(c - 8'h61 + 8'd10);
		end else if (c inside {[8'h41:8'h46]}) begin
			h.val = 4'(c - 8'h41 + 8'd10);
		end else begin
			h.ok = 1'b0;
		end
		return h;
	endfunction

endpackage
`default_nettype wire

@@ rtl/core/rsp_packet_deframer.sv @@
// Remote serial protocol packet deframer: '$' payload '#' hh framing to payload and end beats.
//
// Input channel: in_valid / in_stall with rx_byte, one link byte per beat.
// Output channel: out_valid / out_stall with the result fields, one beat per
// payload byte and one end beat (packet_end = 1) after the second checksum digit.
// Bytes outside a frame and the marker and digit bytes produce no output beat.
// An accepted byte is held in the input register; its result then enters the
// output register when the output is not stalled, and the output beat is taken
// from there. Throughput is one byte per cycle while the output does not stall,
// set by the state update between the two registers.
// A stalled output beat holds; the input register then holds too and in_stall
// rises while it is full, so at most one byte waits behind a stalled result.
// Reset clears the frame state (hunting for '$'), the running sum, the length
// count, the overflow flag and both valid bits.
`default_nettype none
module rsp_packet_deframer (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic [7:0] rx_byte,
	output logic out_valid,
	input wire logic out_stall,
	output logic [7:0] payload_byte,
	output logic packet_end,
	output logic checksum_ok,
	output logic [7:0] computed_sum,
	output logic [7:0] received_sum,
	output logic [rpd_pkg::LEN_W-1:0] payload_length,
	output logic length_overflow
);

	localparam logic [rpd_pkg::LEN_W-1:0] MAX_LEN = rpd_pkg::LEN_W'(rpd_pkg::MAX_PAYLOAD);

	logic valid_s1;
	logic [7:0] byte_s1;
	logic adv;

	rpd_pkg::phase_t phase_q, phase_d;
	logic [7:0] sum_q, sum_d;
	logic [7:0] digit_q, digit_d;
	logic [rpd_pkg::LEN_W-1:0] count_q, count_d;
	logic ovf_q, ovf_d;

	logic res_valid;
	logic [7:0] res_byte;
	logic res_end;
	logic res_ok;
	logic [7:0] res_rx;
	rpd_pkg::hex_t hex_hi, hex_lo;

	assign adv = !out_valid || !out_stall;
	assign in_stall = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= rx_byte;
		end
	end

	assign hex_hi = rpd_pkg::hex_decode(digit_q);
	assign hex_lo = rpd_pkg::hex_decode(byte_s1);
	assign res_rx = {hex_hi.val, hex_lo.val};

	always_comb begin
		phase_d = phase_q;
		sum_d = sum_q;
		digit_d = digit_q;
		count_d = count_q;
		ovf_d = ovf_q;
		res_valid = 1'b0;
		res_byte = 8'd0;
		res_end = 1'b0;
		res_ok = 1'b0;
		case (phase_q)
			rpd_pkg::PH_HUNT: begin
				if (byte_s1 == rpd_pkg::START_MARK) begin
					phase_d = rpd_pkg::PH_PAYLOAD;
				end
			end
			rpd_pkg::PH_PAYLOAD: begin
				if (byte_s1 == rpd_pkg::HASH_MARK) begin
					phase_d = rpd_pkg::PH_DIGIT_HI;
				end else begin
					sum_d = sum_q + byte_s1;
					if (count_q >= MAX_LEN) begin
						ovf_d = 1'b1;
					end else begin
						count_d = count_q + 1'b1;
					end
					res_valid = 1'b1;
					res_byte = byte_s1;
				end
			end
			rpd_pkg::PH_DIGIT_HI: begin
				digit_d = byte_s1;
				phase_d = rpd_pkg::PH_DIGIT_LO;
			end
			rpd_pkg::PH_DIGIT_LO: begin
				res_valid = 1'b1;
				res_end = 1'b1;
				res_ok = hex_hi.ok && hex_lo.ok && (res_rx == sum_q);
				phase_d = rpd_pkg::PH_HUNT;
				sum_d = 8'd0;
				count_d = '0;
				ovf_d = 1'b0;
			end
			default: begin
				phase_d = rpd_pkg::PH_HUNT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= rpd_pkg::PH_HUNT;
			sum_q <= 8'd0;
			digit_q <= 8'd0;
			count_q <= '0;
			ovf_q <= 1'b0;
		end else if (valid_s1 && adv) begin
			phase_q <= phase_d;
			sum_q <= sum_d;
			digit_q <= digit_d;
			count_q <= count_d;
			ovf_q <= ovf_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= valid_s1 && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1 && res_valid) begin
			payload_byte <= res_byte;
			packet_end <= res_end;
			checksum_ok <= res_ok;
			computed_sum <= res_end ? sum_q : 8'd0;
			received_sum <= res_end ? res_rx : 8'd0;
			payload_length <= res_end ? count_q : '0;
			length_overflow <= res_end ? ovf_q : 1'b0;
		end
	end

	a_end_no_byte: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && packet_end |-> payload_byte == 8'd0)
		else $error("end beat carries a payload byte");

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> payload_length <= MAX_LEN)
		else $error("payload length above bound");

	a_ovf_sat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && length_overflow |-> payload_length == MAX_LEN)
		else $error("overflow without saturated length");

	a_payload_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !packet_end |-> !checksum_ok && !length_overflow && computed_sum == 8'd0)
		else $error("payload beat carries end fields");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |-> count_q == MAX_LEN)
		else $error("overflow flag set below bound");

endmodule
`default_nettype wire

@@ bench/rsp_checker.sv @@
`timescale 1ns / 100ps
// Checker for the packet deframer: predicts output beats from accepted link bytes and compares.
module rsp_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic [7:0] rx_byte,
	input logic out_valid,
	input logic out_stall,
	input logic [7:0] payload_byte,
	input logic packet_end,
	input logic checksum_ok,
	input logic [7:0] computed_sum,
	input logic [7:0] received_sum,
	input logic [rpd_pkg::LEN_W-1:0] payload_length,
	input logic length_overflow,
	output int fail_count,
	output int pending,
	output int payload_beats,
	output int frames_closed
);

	localparam logic [7:0] CH_ZERO = "0";
	localparam logic [7:0] CH_NINE = "9";
	localparam logic [7:0] CH_LO_A = "a";
	localparam logic [7:0] CH_LO_F = "f";
	localparam logic [7:0] CH_UP_A = "A";
	localparam logic [7:0] CH_UP_F = "F";

	typedef struct packed {
		logic [7:0] data;
		logic eop;
		logic ok;
		logic [7:0] csum;
		logic [7:0] rsum;
		logic [rpd_pkg::LEN_W-1:0] len;
		logic ovf;
	} beat_t;

	beat_t expected_beats[$];
	beat_t seen_beat;
	beat_t want_beat;

	rpd_pkg::phase_t frame_state;
	logic [7:0] sum_acc;
	logic [7:0] hi_digit;
	logic [rpd_pkg::LEN_W-1:0] byte_count;
	logic long_seen;

	// {valid, value} of one hex character
	function automatic logic [4:0] hex_nibble(input logic [7:0] c);
		if (c >= CH_ZERO && c <= CH_NINE) return {1'b1, 4'(c - CH_ZERO)};
		if (c >= CH_LO_A && c <= CH_LO_F) return {1'b1, 4'(c - CH_LO_A + 8'd10)};
		if (c >= CH_UP_A && c <= CH_UP_F) return {1'b1, 4'(c - CH_UP_A + 8'd10)};
		return 5'd0;
	endfunction

	function automatic string beat_str(input beat_t x);
		return $sformatf("data=%h end=%b ok=%b csum=%h rsum=%h len=%0d ovf=%b",
			x.data, x.eop, x.ok, x.csum, x.rsum, x.len, x.ovf);
	endfunction

	task automatic report_mismatch(input string what);
		if (fail_count < 30) $display("%0t ns mismatch: %s", $time, what);
		fail_count++;
	endtask

	task automatic deframe_byte(input logic [7:0] b);
		beat_t r;
		logic [4:0] h;
		logic [4:0] l;
		r = '0;
		case (frame_state)
			rpd_pkg::PH_HUNT: begin
				if (b == rpd_pkg::START_MARK) frame_state = rpd_pkg::PH_PAYLOAD;
			end
			rpd_pkg::PH_PAYLOAD: begin
				if (b == rpd_pkg::HASH_MARK) begin
					frame_state = rpd_pkg::PH_DIGIT_HI;
				end else begin
					sum_acc = sum_acc + b;
					if (byte_count >= rpd_pkg::MAX_PAYLOAD) long_seen = 1'b1;
					else byte_count = byte_count + 1'b1;
					r.data = b;
					expected_beats.push_back(r);
				end
			end
			rpd_pkg::PH_DIGIT_HI: begin
				hi_digit = b;
				frame_state = rpd_pkg::PH_DIGIT_LO;
			end
			default: begin
				h = hex_nibble(hi_digit);
				l = hex_nibble(b);
				r.eop = 1'b1;
				r.rsum = {h[3:0], l[3:0]};
				r.csum = sum_acc;
				r.ok = h[4] && l[4] && (r.rsum == sum_acc);
				r.len = byte_count;
				r.ovf = long_seen;
				expected_beats.push_back(r);
				frame_state = rpd_pkg::PH_HUNT;
				sum_acc = '0;
				byte_count = '0;
				long_seen = 1'b0;
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_state = rpd_pkg::PH_HUNT;
			sum_acc = '0;
			hi_digit = '0;
			byte_count = '0;
			long_seen = 1'b0;
			expected_beats.delete();
		end else begin
			if (out_valid && !out_stall) begin
				seen_beat = {payload_byte, packet_end, checksum_ok, computed_sum,
					received_sum, payload_length, length_overflow};
				if (seen_beat.eop) frames_closed++;
				else payload_beats++;
				if (expected_beats.size() == 0) begin
					report_mismatch($sformatf("unexpected beat data=%h end=%b",
						seen_beat.data, seen_beat.eop));
				end else begin
					want_beat = expected_beats.pop_front();
					if (seen_beat !== want_beat)
						report_mismatch($sformatf("got %s, want %s",
							beat_str(seen_beat), beat_str(want_beat)));
				end
			end
			if (in_valid && !in_stall) deframe_byte(rx_byte);
		end
		pending = expected_beats.size();
	end

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 100ps
// Testbench top for the packet deframer: clock, reset, framed byte stimulus and verdict.
module tb_top;

	localparam int ITEM_TARGET = 1700;
	localparam logic [7:0] CH_ZERO = "0";
	localparam logic [7:0] CH_UP_A = "A";
	localparam logic [7:0] CH_LO_A = "a";

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic [7:0] rx_byte;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [7:0] payload_byte;
	logic packet_end;
	logic checksum_ok;
	logic [7:0] computed_sum;
	logic [7:0] received_sum;
	logic [rpd_pkg::LEN_W-1:0] payload_length;
	logic length_overflow;

	int fail_count;
	int pending;
	int payload_beats;
	int frames_closed;
	int bytes_sent = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int longest_frame = 0;

	rsp_packet_deframer dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.payload_byte(payload_byte),
		.packet_end(packet_end),
		.checksum_ok(checksum_ok),
		.computed_sum(computed_sum),
		.received_sum(received_sum),
		.payload_length(payload_length),
		.length_overflow(length_overflow)
	);

	rsp_checker chk (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.payload_byte(payload_byte),
		.packet_end(packet_end),
		.checksum_ok(checksum_ok),
		.computed_sum(computed_sum),
		.received_sum(received_sum),
		.payload_length(payload_length),
		.length_overflow(length_overflow),
		.fail_count(fail_count),
		.pending(pending),
		.payload_beats(payload_beats),
		.frames_closed(frames_closed)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(negedge clk) begin
		if (!arst_n) out_stall <= 1'b0;
		else out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
	end

	initial begin
		#10_000_000;
		$display("rsp_packet_deframer test failed");
		$finish;
	end

	function automatic logic [7:0] hex_char(input logic [3:0] n, input logic upper);
		if (n < 4'd10) return CH_ZERO + 8'(n);
		return (upper ? CH_UP_A : CH_LO_A) + 8'(n) - 8'd10;
	endfunction

	task automatic push_byte(input logic [7:0] b);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (in_stall);
		bytes_sent++;
	endtask

	// noise, '$', payload, '#', two digits; sometimes a bad checksum or a cut-off frame
	task automatic send_frame(input int len, input logic force_good);
		logic [7:0] b;
		logic [7:0] sum;
		int n;
		int pick;
		sum = '0;
		n = $urandom_range(0, 2);
		repeat (n) begin
			b = 8'($urandom_range(0, 255));
			if (b == rpd_pkg::START_MARK) b = b ^ 8'h01;
			push_byte(b);
		end
		push_byte(rpd_pkg::START_MARK);
		repeat (len) begin
			b = 8'($urandom_range(0, 255));
			if (b == rpd_pkg::HASH_MARK) b = rpd_pkg::START_MARK;
			sum = sum + b;
			push_byte(b);
		end
		if (!force_good && $urandom_range(0, 99) < 4) return;
		push_byte(rpd_pkg::HASH_MARK);
		pick = force_good ? 0 : $urandom_range(0, 99);
		if (pick < 75) begin
			push_byte(hex_char(sum[7:4], 1'($urandom_range(0, 1))));
			push_byte(hex_char(sum[3:0], 1'($urandom_range(0, 1))));
		end else if (pick < 88) begin
			push_byte(hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))));
			push_byte(hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))));
		end else begin
			repeat (2) begin
				case ($urandom_range(0, 3))
					0: b = rpd_pkg::HASH_MARK;
					1: b = rpd_pkg::START_MARK;
					default: b = 8'($urandom_range(0, 255));
				endcase
				push_byte(b);
			end
		end
		if (len > longest_frame) longest_frame = len;
	endtask

	function automatic int frame_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 85) return $urandom_range(0, 8);
		if (r < 97) return $urandom_range(9, 40);
		return $urandom_range(41, 300);
	endfunction

	initial begin
		logic [7:0] directed[] = {
			8'h00, 8'hFF, rpd_pkg::HASH_MARK,
			rpd_pkg::START_MARK, rpd_pkg::HASH_MARK, "0", "0",
			rpd_pkg::START_MARK, 8'hFF, 8'h00, rpd_pkg::START_MARK, rpd_pkg::HASH_MARK,
			"2", "3",
			rpd_pkg::START_MARK, "A", rpd_pkg::HASH_MARK, "z", "1",
			rpd_pkg::START_MARK, 8'hAB, rpd_pkg::HASH_MARK, "a", "B"
		};
		arst_n = 1'b0;
		in_valid = 1'b0;
		rx_byte = '0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		send_idle_pct = 25;
		recv_idle_pct = 53;
		foreach (directed[i]) push_byte(directed[i]);

		for (int ph = 0; ph < 3; ph++) begin
			case (ph)
				0: begin send_idle_pct = 25; recv_idle_pct = 53; end
				1: begin send_idle_pct = 53; recv_idle_pct = 25; end
				default: begin send_idle_pct = 0; recv_idle_pct = 0; end
			endcase
			while (bytes_sent < (ph + 1) * ITEM_TARGET / 3)
				send_frame(frame_len(), 1'b0);
		end
		send_frame(3, 1'b1);

		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (10) @(posedge clk);

		$display("sent %0d link bytes; checked %0d payload beats and %0d packet ends",
			bytes_sent, payload_beats, frames_closed);
		$display("idle mixes: sender-heavy, receiver-heavy, none; longest payload %0d bytes",
			longest_frame);
		if (fail_count == 0)
			$display("rsp_packet_deframer test passed");
		else
			$display("rsp_packet_deframer test failed");
		$finish;
	end

endmodule
